### rtl/ier_pkg.sv
// Shared types and constants for the ICMP echo reply rewriter.
package ier_pkg;

  localparam int unsigned HDR_LEN = 29;
  localparam int unsigned POS_W   = $clog2(HDR_LEN);

  localparam logic [POS_W-1:0] DECIDE_POS = POS_W'(HDR_LEN - 1);
  localparam logic [POS_W-1:0] TYPE_POS   = POS_W'(20);
  localparam logic [POS_W-1:0] SUM_LO_POS = POS_W'(22);
  localparam logic [POS_W-1:0] SUM_HI_POS = POS_W'(23);
  localparam logic [POS_W-1:0] SRC_IP_POS = POS_W'(12);
  localparam logic [POS_W-1:0] DST_IP_POS = POS_W'(16);

  localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  ICMP_ECHO_REQ = 8'h08;
  localparam logic [7:0]  ICMP_ECHO_REP = 8'h00;
  localparam logic [7:0]  SUM_ADJUST    = 8'h08;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_EMIT,
    ST_PASS,
    ST_DISCARD
  } ier_state_t;

  typedef struct packed {
    logic store_byte;
    logic start_emit;
    logic emit_load;
    logic pass_load;
  } ier_cmd_t;

  typedef struct packed {
    logic pos_decide;
    logic check_ok;
    logic idx_last;
    logic out_free;
  } ier_stat_t;

endpackage

### rtl/ier_ctrl.sv
// Controller state machine for the ICMP echo reply rewriter.
module ier_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  ier_pkg::ier_stat_t stat,
  output ier_pkg::ier_cmd_t  cmd
);
  import ier_pkg::*;

  ier_state_t state;
  ier_state_t state_next;
  logic       accept;
  logic       cmd_last_saved;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (accept && stat.pos_decide) begin
          if (stat.check_ok) begin
            state_next = ST_EMIT;
          end else if (!in_last) begin
            state_next = ST_DISCARD;
          end
        end
      end
      ST_EMIT: begin
        if (stat.out_free && stat.idx_last) begin
          state_next = ST_PASS;
        end
      end
      ST_PASS: begin
        if (accept && in_last) begin
          state_next = ST_COLLECT;
        end
      end
      ST_DISCARD: begin
        if (accept && in_last) begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
    // a reply that ended on the decision byte has nothing to pass through
    if (state == ST_EMIT && stat.out_free && stat.idx_last && cmd_last_saved) begin
      state_next = ST_COLLECT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_last_saved <= 1'b0;
    end else if (state == ST_COLLECT && accept && stat.pos_decide && stat.check_ok) begin
      cmd_last_saved <= in_last;
    end
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.store_byte = 1'b0;
    cmd.start_emit = 1'b0;
    cmd.emit_load  = 1'b0;
    cmd.pass_load  = 1'b0;
    unique case (state)
      ST_COLLECT: begin
        in_ready       = 1'b1;
        cmd.store_byte = accept;
        cmd.start_emit = accept && stat.pos_decide && stat.check_ok;
      end
      ST_EMIT: begin
        cmd.emit_load = stat.out_free;
      end
      ST_PASS: begin
        in_ready      = stat.out_free;
        cmd.pass_load = accept;
      end
      ST_DISCARD: begin
        in_ready = 1'b1;
      end
      default: in_ready = 1'b0;
    endcase
  end

endmodule

### rtl/ier_dp.sv
// Datapath for the ICMP echo reply rewriter: header store, counters, output register.
module ier_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [47:0]        cfg_wdata,
  input  logic [7:0]         data_byte,
  input  logic               end_of_packet,
  input  logic [47:0]        dest_mac,
  input  logic [15:0]        ether_type,
  input  ier_pkg::ier_cmd_t  cmd,
  output ier_pkg::ier_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         reply_byte,
  output logic               last_of_reply
);
  import ier_pkg::*;

  logic [47:0]      own_mac;
  logic             frame_matches;
  logic [7:0]       header_store [HDR_LEN];
  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] emit_idx;
  logic             eop_saved;
  logic [POS_W-1:0] src_idx;
  logic [7:0]       xform_byte;
  logic             sum_carry;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
    end else if (cfg_wen) begin
      own_mac <= cfg_wdata;
    end
  end

  // sample the address check on the first byte; advance or restart the position
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_matches <= 1'b0;
      byte_position <= '0;
    end else if (cmd.store_byte) begin
      if (byte_position == '0) begin
        frame_matches <= (dest_mac == own_mac) && (ether_type == ETYPE_IPV4);
      end
      if (end_of_packet || byte_position == DECIDE_POS) begin
        byte_position <= '0;
      end else begin
        byte_position <= byte_position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      header_store[byte_position] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx  <= '0;
      eop_saved <= 1'b0;
    end else if (cmd.start_emit) begin
      emit_idx  <= '0;
      eop_saved <= end_of_packet;
    end else if (cmd.emit_load) begin
      emit_idx <= emit_idx + 1'b1;
    end
  end

  // swap the IP addresses, clear the ICMP type, raise the checksum word
  always_comb begin
    if (emit_idx >= SRC_IP_POS && emit_idx < DST_IP_POS) begin
      src_idx = emit_idx + POS_W'(4);
    end else if (emit_idx >= DST_IP_POS && emit_idx < TYPE_POS) begin
      src_idx = emit_idx - POS_W'(4);
    end else begin
      src_idx = emit_idx;
    end
    sum_carry = (header_store[SUM_LO_POS] >= (8'hFF - SUM_ADJUST + 8'h01));
    if (emit_idx == TYPE_POS) begin
      xform_byte = ICMP_ECHO_REP;
    end else if (emit_idx == SUM_LO_POS) begin
      xform_byte = header_store[SUM_LO_POS] + SUM_ADJUST;
    end else if (emit_idx == SUM_HI_POS) begin
      xform_byte = header_store[SUM_HI_POS] + {7'd0, sum_carry};
    end else begin
      xform_byte = header_store[src_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load || cmd.pass_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      reply_byte    <= xform_byte;
      last_of_reply <= eop_saved && (emit_idx == DECIDE_POS);
    end else if (cmd.pass_load) begin
      reply_byte    <= data_byte;
      last_of_reply <= end_of_packet;
    end
  end

  assign stat.pos_decide = (byte_position == DECIDE_POS);
  assign stat.check_ok   = frame_matches && (header_store[TYPE_POS] == ICMP_ECHO_REQ);
  assign stat.idx_last   = (emit_idx == DECIDE_POS);
  assign stat.out_free   = !out_valid || out_ready;

endmodule

### rtl/icmp_echo_reply_rewriter.sv
// Top level of the ICMP echo reply rewriter: controller plus datapath.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+----------------------------------------------------
//  s_*     | in  | s_tvalid / s_tready | tdata: data_byte, dest_mac, ether_type; tlast: eop
//  m_*     | out | m_tvalid / m_tready | tdata: reply_byte; tlast: last_of_reply
//  cfg_*   | in  | cfg_wen             | cfg_wdata: own_mac
//
// Header bytes 0..28 are taken one per cycle; on byte 28 of a matching echo request
// input stops while the rewritten header leaves the store, one byte a cycle when m_tready allows.
// Payload bytes then pass through at one per cycle when m_tready allows; the output register takes a new byte
// in the cycle the previous one is taken. Rejected and short packets drop at one per cycle.
// Reset: rst is synchronous and clears the controller, counters and valid bits.
// Stall: m_tready low holds the output register and, in pass-through, s_tready.
module icmp_echo_reply_rewriter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [47:0] cfg_wdata,  // own_mac
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,    // [7:0] data_byte, [55:8] dest_mac, [71:56] ether_type
  input  logic        s_tlast,    // end_of_packet
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [7:0] reply_byte
  output logic        m_tlast     // last_of_reply
);
  import ier_pkg::*;

  ier_cmd_t  cmd;
  ier_stat_t stat;

  // sequence the header capture, the reply burst and pass-through
  ier_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // hold the header, build the reply bytes, drive the output register
  ier_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .data_byte     (s_tdata[7:0]),
    .end_of_packet (s_tlast),
    .dest_mac      (s_tdata[55:8]),
    .ether_type    (s_tdata[71:56]),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .reply_byte    (m_tdata),
    .last_of_reply (m_tlast)
  );

`ifndef ASSERT_OFF
  // input pauses once a reply burst starts
  a_emit_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.start_emit |=> !s_tready)
    else $error("input accepted right after reply burst start");

  // byte capture and pass-through happen only on an accepted input transaction
  a_cmd_on_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.store_byte || cmd.pass_load) |-> (s_tvalid && s_tready))
    else $error("datapath command without input transaction");

  // the output register never takes two sources at once
  a_single_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit_load && cmd.pass_load))
    else $error("emit and pass-through load together");

  // a load never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_load || cmd.pass_load) |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while stalled");
`endif

endmodule
